// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file owm_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/owm_pkg.sv -----
// Package for the 1-Wire bus master: op codes, register indexes, shared types.
// No dependencies.
package owm_pkg;

  localparam int CounterWidthDefault = 11;
  localparam int CfgW = 11;
  localparam int AddrW = 5;
  localparam logic [7:0] ReadRecoveryTicks = 8'd55;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_RESET   = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_TRIPLET = 3'd4;
  localparam logic [2:0] OP_NOP     = 3'd5;
  localparam logic [2:0] KindMax    = OP_TRIPLET;

  localparam logic [2:0] REG_RESET_LOW      = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT  = 3'd1;
  localparam logic [2:0] REG_RESET_RECOVERY = 3'd2;
  localparam logic [2:0] REG_SHORT_LOW      = 3'd3;
  localparam logic [2:0] REG_W1_RELEASE     = 3'd4;
  localparam logic [2:0] REG_W0_LOW         = 3'd5;
  localparam logic [2:0] REG_W0_RELEASE     = 3'd6;
  localparam logic [2:0] REG_READ_SAMPLE    = 3'd7;

  localparam logic [10:0] RstResetLow      = 11'd500;
  localparam logic [10:0] RstPresenceWait  = 11'd70;
  localparam logic [10:0] RstResetRecovery = 11'd1000;
  localparam logic [7:0]  RstShortLow      = 8'd6;
  localparam logic [7:0]  RstW1Release     = 8'd6;
  localparam logic [7:0]  RstW0Low         = 8'd60;
  localparam logic [7:0]  RstW0Release     = 8'd10;
  localparam logic [7:0]  RstReadSample    = 8'd9;

  typedef struct packed {
    logic [10:0] reset_low_ticks;
    logic [10:0] presence_wait_ticks;
    logic [10:0] reset_recovery_ticks;
    logic [7:0]  short_low_ticks;
    logic [7:0]  write_one_release_ticks;
    logic [7:0]  write_zero_low_ticks;
    logic [7:0]  write_zero_release_ticks;
    logic [7:0]  read_sample_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] write_value;
    logic       search_direction;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       presence;
    logic       direction_taken;
    logic       discrepancy;
    logic       no_response;
    logic       rejected;
  } result_t;

endpackage

// ----- hdl/owm_if.sv -----
// Valid/ready channel interfaces for the 1-Wire master: request and response.
// No dependencies.
interface owm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] write_value;
  logic       search_direction;
  logic       line_level;

  modport source (output valid, kind, write_value, search_direction, line_level,
                  input ready);
  modport sink (input valid, kind, write_value, search_direction, line_level,
                output ready);
endinterface

interface owm_rsp_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_value;
  logic       presence;
  logic       direction_taken;
  logic       discrepancy;
  logic       no_response;
  logic       rejected;

  modport source (output valid, drive_low, busy_res, done_res, read_value, presence,
                  direction_taken, discrepancy, no_response, rejected,
                  input ready);
  modport sink (input valid, drive_low, busy_res, done_res, read_value, presence,
                direction_taken, discrepancy, no_response, rejected,
                output ready);
endinterface

// ----- hdl/owm_front.sv -----
// Front end: classifies request beats and holds them in a two-entry queue.
// Depends on owm_pkg and owm_req_if.
module owm_front (
  input  logic           clk,
  input  logic           rst,
  owm_req_if.sink        req,
  input  logic           pop,
  output owm_pkg::head_t head
);
  import owm_pkg::*;

  localparam logic [1:0] Full = 2'd2;

  item_t      entries [2];
  item_t      incoming;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    incoming.op               = (req.kind > KindMax) ? OP_NOP : req.kind;
    incoming.write_value      = req.write_value;
    incoming.search_direction = req.search_direction;
    incoming.line_level       = req.line_level;
  end

  assign req.ready = (count != Full);
  assign push      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

endmodule

// ----- hdl/owm_back.sv -----
// Back end: bus timing engine, one queued beat per cycle unless the response stalls, registered response.
// Depends on owm_pkg and owm_rsp_if.
module owm_back #(
  parameter int CounterWidth = owm_pkg::CounterWidthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  owm_pkg::cfg_t  cfg,
  input  owm_pkg::head_t head,
  output logic           pop,
  owm_rsp_if.source      rsp
);
  import owm_pkg::*;

  localparam int LenW = (CounterWidth > CfgW) ? CounterWidth : CfgW;
  localparam logic [LenW-1:0] MaxLen = LenW'((1 << CounterWidth) - 1);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RST_LOW  = 4'd1;
  localparam logic [3:0] PH_RST_WAIT = 4'd2;
  localparam logic [3:0] PH_RST_REC  = 4'd3;
  localparam logic [3:0] PH_RD_LOW   = 4'd4;
  localparam logic [3:0] PH_RD_WAIT  = 4'd5;
  localparam logic [3:0] PH_RD_REC   = 4'd6;
  localparam logic [3:0] PH_WR_LOW   = 4'd7;
  localparam logic [3:0] PH_WR_REL   = 4'd8;

  typedef struct packed {
    logic [3:0]              phase;
    logic [CounterWidth-1:0] tick_count;
    logic [2:0]              bit_index;
    logic [7:0]              shift_byte;
    logic [2:0]              active_command;
    logic [1:0]              triplet_bits;
    logic                    held_direction;
    logic                    finished;
  } eng_t;

  logic [3:0]              phase;
  logic [CounterWidth-1:0] tick_count;
  logic [2:0]              bit_index;
  logic [7:0]              shift_byte;
  logic [2:0]              active_command;
  logic [1:0]              triplet_bits;
  logic                    held_direction;

  eng_t    cur;
  eng_t    nxt;
  result_t res;
  result_t res_q;
  logic    res_valid;
  logic    rejected;

  function automatic logic [LenW-1:0] clampd(input logic [CfgW-1:0] d);
    logic [LenW-1:0] e;
    e = LenW'(d);
    return (e > MaxLen) ? MaxLen : e;
  endfunction

  function automatic logic [CfgW-1:0] atleast1(input logic [CfgW-1:0] d);
    return (d == '0) ? CfgW'(1) : d;
  endfunction

  function automatic logic one_write(input eng_t s);
    return (s.active_command == OP_TRIPLET) && s.held_direction;
  endfunction

  function automatic logic [LenW-1:0] phase_len(input eng_t s, input cfg_t c);
    logic [LenW-1:0] len;
    case (s.phase)
      PH_RST_LOW:  len = clampd(atleast1(c.reset_low_ticks));
      PH_RST_WAIT: len = clampd(atleast1(c.presence_wait_ticks));
      PH_RST_REC:  len = clampd(c.reset_recovery_ticks);
      PH_RD_LOW:   len = clampd(atleast1(CfgW'(c.short_low_ticks)));
      PH_RD_WAIT:  len = clampd(CfgW'(c.read_sample_ticks));
      PH_RD_REC:   len = clampd(CfgW'(ReadRecoveryTicks));
      PH_WR_LOW:   len = clampd(atleast1(one_write(s) ? CfgW'(c.short_low_ticks)
                                                      : CfgW'(c.write_zero_low_ticks)));
      PH_WR_REL:   len = clampd(one_write(s) ? CfgW'(c.write_one_release_ticks)
                                             : CfgW'(c.write_zero_release_ticks));
      default:     len = LenW'(1);
    endcase
    return len;
  endfunction

  function automatic eng_t enter(input eng_t s, input logic [3:0] p);
    eng_t r;
    r            = s;
    r.phase      = p;
    r.tick_count = '0;
    return r;
  endfunction

  function automatic eng_t start_slot(input eng_t s);
    eng_t r;
    if (s.active_command == OP_WRITE) begin
      r = enter(s, s.shift_byte[0] ? PH_RD_LOW : PH_WR_LOW);
    end else if (s.active_command == OP_TRIPLET && s.bit_index == 3'd2) begin
      r = enter(s, PH_WR_LOW);
    end else begin
      r = enter(s, PH_RD_LOW);
    end
    return r;
  endfunction

  function automatic eng_t finish(input eng_t s);
    eng_t r;
    r          = enter(s, PH_IDLE);
    r.finished = 1'b1;
    return r;
  endfunction

  function automatic eng_t bit_complete(input eng_t s);
    eng_t r;
    r = s;
    if (s.active_command == OP_TRIPLET) begin
      if (s.bit_index == 3'd0) begin
        r.bit_index = 3'd1;
        r = start_slot(r);
      end else if (s.bit_index == 3'd1) begin
        if (s.triplet_bits == 2'b11) begin
          r = finish(r);
        end else begin
          if (s.triplet_bits[0] != s.triplet_bits[1]) begin
            r.held_direction = s.triplet_bits[0];
          end
          r.bit_index = 3'd2;
          r = start_slot(r);
        end
      end else begin
        r = finish(r);
      end
    end else if (s.bit_index == 3'd7) begin
      r = finish(r);
    end else begin
      r.bit_index = s.bit_index + 3'd1;
      if (s.active_command == OP_WRITE) begin
        r.shift_byte = {1'b0, s.shift_byte[7:1]};
      end
      r = start_slot(r);
    end
    return r;
  endfunction

  function automatic eng_t end_phase(input eng_t s, input logic level);
    eng_t r;
    r = s;
    case (s.phase)
      PH_RST_LOW: r = enter(r, PH_RST_WAIT);
      PH_RST_WAIT: begin
        r.triplet_bits = {1'b0, ~level};
        r = enter(r, PH_RST_REC);
      end
      PH_RST_REC: r = finish(r);
      PH_RD_LOW: r = enter(r, PH_RD_WAIT);
      PH_RD_WAIT: begin
        if (s.active_command == OP_READ) begin
          r.shift_byte = {level, s.shift_byte[7:1]};
        end else if (s.active_command == OP_TRIPLET) begin
          if (s.bit_index[0]) begin
            r.triplet_bits[1] = s.triplet_bits[1] | level;
          end else begin
            r.triplet_bits[0] = s.triplet_bits[0] | level;
          end
        end
        r = enter(r, PH_RD_REC);
      end
      PH_RD_REC: r = bit_complete(r);
      PH_WR_LOW: r = enter(r, PH_WR_REL);
      PH_WR_REL: r = bit_complete(r);
      default: r = enter(r, PH_IDLE);
    endcase
    return r;
  endfunction

  always_comb begin
    cur.phase          = phase;
    cur.tick_count     = tick_count;
    cur.bit_index      = bit_index;
    cur.shift_byte     = shift_byte;
    cur.active_command = active_command;
    cur.triplet_bits   = triplet_bits;
    cur.held_direction = held_direction;
    cur.finished       = 1'b0;
    nxt      = cur;
    rejected = 1'b0;
    case (head.item.op)
      OP_TICK: begin
        if (cur.phase != PH_IDLE) begin
          nxt.tick_count = cur.tick_count + CounterWidth'(1);
          if (LenW'(nxt.tick_count) >= phase_len(nxt, cfg)) begin
            nxt = end_phase(nxt, head.item.line_level);
            // zero-length phases resolve within the same tick
            if (nxt.phase != PH_IDLE && phase_len(nxt, cfg) == '0) begin
              nxt = end_phase(nxt, head.item.line_level);
            end
          end
        end
      end
      OP_RESET, OP_WRITE, OP_READ, OP_TRIPLET: begin
        if (cur.phase != PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          nxt.active_command = head.item.op;
          nxt.bit_index      = 3'd0;
          nxt.triplet_bits   = 2'b00;
          if (head.item.op == OP_RESET) begin
            nxt = enter(nxt, PH_RST_LOW);
          end else begin
            nxt.shift_byte = (head.item.op == OP_WRITE) ? head.item.write_value : 8'd0;
            if (head.item.op == OP_TRIPLET) begin
              nxt.held_direction = head.item.search_direction;
            end
            nxt = start_slot(nxt);
          end
        end
      end
      default: ;
    endcase

    res                 = '0;
    res.drive_low       = (nxt.phase == PH_RST_LOW) || (nxt.phase == PH_RD_LOW) ||
                          (nxt.phase == PH_WR_LOW);
    res.busy_res        = (nxt.phase != PH_IDLE);
    res.done_res        = nxt.finished;
    res.rejected        = rejected;
    if (nxt.finished) begin
      if (nxt.active_command == OP_READ) begin
        res.read_value = nxt.shift_byte;
      end else if (nxt.active_command == OP_RESET) begin
        res.presence = nxt.triplet_bits[0];
      end else if (nxt.active_command == OP_TRIPLET) begin
        if (nxt.triplet_bits == 2'b11) begin
          res.no_response = 1'b1;
        end else begin
          res.direction_taken = nxt.held_direction;
          res.discrepancy     = (nxt.triplet_bits == 2'b00);
        end
      end
    end
  end

  assign pop = head.valid && (!res_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      bit_index      <= 3'd0;
      shift_byte     <= 8'd0;
      active_command <= 3'd0;
      triplet_bits   <= 2'b00;
      held_direction <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (pop) begin
        phase          <= nxt.phase;
        tick_count     <= nxt.tick_count;
        bit_index      <= nxt.bit_index;
        shift_byte     <= nxt.shift_byte;
        active_command <= nxt.active_command;
        triplet_bits   <= nxt.triplet_bits;
        held_direction <= nxt.held_direction;
        res_valid      <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_q <= res;
    end
  end

  assign rsp.valid           = res_valid;
  assign rsp.drive_low       = res_q.drive_low;
  assign rsp.busy_res        = res_q.busy_res;
  assign rsp.done_res        = res_q.done_res;
  assign rsp.read_value      = res_q.read_value;
  assign rsp.presence        = res_q.presence;
  assign rsp.direction_taken = res_q.direction_taken;
  assign rsp.discrepancy     = res_q.discrepancy;
  assign rsp.no_response     = res_q.no_response;
  assign rsp.rejected        = res_q.rejected;

endmodule

// ----- hdl/onewire_bus_master_top.sv -----
// Top level of the 1-Wire bus master: timing registers, front queue, engine.
// Depends on owm_pkg, owm_if, owm_front and owm_back.
//
// Takes one request beat per clock while the front queue has room, tick or
// command alike, and returns one response beat for each, in order. A beat
// passes through the two-entry front queue and then the execute stage, whose
// registered output is the response; throughput is one beat per cycle unless
// the response channel stalls. Timing registers sit on the APB port at 4*i.
module onewire_bus_master_top #(
  parameter int CounterWidth = owm_pkg::CounterWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  owm_req_if.sink                  req,
  owm_rsp_if.source                rsp,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [owm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import owm_pkg::*;

  cfg_t       cfg;
  head_t      head;
  logic       pop;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks          <= RstResetLow;
      cfg.presence_wait_ticks      <= RstPresenceWait;
      cfg.reset_recovery_ticks     <= RstResetRecovery;
      cfg.short_low_ticks          <= RstShortLow;
      cfg.write_one_release_ticks  <= RstW1Release;
      cfg.write_zero_low_ticks     <= RstW0Low;
      cfg.write_zero_release_ticks <= RstW0Release;
      cfg.read_sample_ticks        <= RstReadSample;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_RESET_LOW:      cfg.reset_low_ticks          <= pwdata[10:0];
        REG_PRESENCE_WAIT:  cfg.presence_wait_ticks      <= pwdata[10:0];
        REG_RESET_RECOVERY: cfg.reset_recovery_ticks     <= pwdata[10:0];
        REG_SHORT_LOW:      cfg.short_low_ticks          <= pwdata[7:0];
        REG_W1_RELEASE:     cfg.write_one_release_ticks  <= pwdata[7:0];
        REG_W0_LOW:         cfg.write_zero_low_ticks     <= pwdata[7:0];
        REG_W0_RELEASE:     cfg.write_zero_release_ticks <= pwdata[7:0];
        REG_READ_SAMPLE:    cfg.read_sample_ticks        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_RESET_LOW:      prdata = 32'(cfg.reset_low_ticks);
      REG_PRESENCE_WAIT:  prdata = 32'(cfg.presence_wait_ticks);
      REG_RESET_RECOVERY: prdata = 32'(cfg.reset_recovery_ticks);
      REG_SHORT_LOW:      prdata = 32'(cfg.short_low_ticks);
      REG_W1_RELEASE:     prdata = 32'(cfg.write_one_release_ticks);
      REG_W0_LOW:         prdata = 32'(cfg.write_zero_low_ticks);
      REG_W0_RELEASE:     prdata = 32'(cfg.write_zero_release_ticks);
      REG_READ_SAMPLE:    prdata = 32'(cfg.read_sample_ticks);
      default:            prdata = 32'd0;
    endcase
  end

  owm_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .pop  (pop),
    .head (head)
  );

  owm_back #(
    .CounterWidth (CounterWidth)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule

// ----- hdl/owm_checker.sv -----
// Port-level checks on the 1-Wire master response channel, bound to the top.
// Depends on assert_macros.svh and onewire_bus_master_top.
`include "assert_macros.svh"

module owm_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       drive_low,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_value,
  input logic       presence,
  input logic       direction_taken,
  input logic       discrepancy,
  input logic       no_response,
  input logic       rejected
);

  logic [15:0] payload;
  logic        dir_flags;

  assign payload   = {drive_low, busy_res, done_res, read_value, presence, direction_taken,
                      discrepancy, no_response, rejected};
  assign dir_flags = direction_taken || discrepancy;

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(payload))

  `ASSERT_IMPLIES(a_done_not_busy, clk, rst, rsp_valid && done_res, !busy_res && !rejected)

  `ASSERT_IMPLIES(a_low_when_busy, clk, rst, rsp_valid && drive_low, busy_res)

  `ASSERT_IMPLIES(a_reject_busy, clk, rst, rsp_valid && rejected, busy_res && !done_res)

  `ASSERT_IMPLIES(a_no_resp_clean, clk, rst, rsp_valid && no_response, done_res && !dir_flags)

endmodule

bind onewire_bus_master_top owm_checker u_owm_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .drive_low       (rsp.drive_low),
  .busy_res        (rsp.busy_res),
  .done_res        (rsp.done_res),
  .read_value      (rsp.read_value),
  .presence        (rsp.presence),
  .direction_taken (rsp.direction_taken),
  .discrepancy     (rsp.discrepancy),
  .no_response     (rsp.no_response),
  .rejected        (rsp.rejected)
);
